// ----- rtl/osd_pkg.sv -----
// Shared types, constants and header-selection functions for the oximeter deframer.
package osd_pkg;

  localparam int unsigned HEADER_WINDOW = 30;
  localparam int unsigned WCNT_W = $clog2(HEADER_WINDOW + 1);
  localparam logic [WCNT_W-1:0] HDR_WIN = WCNT_W'(HEADER_WINDOW);

  localparam logic [7:0] SYNC_BIT   = 8'h80;
  localparam logic [7:0] HDR_MARK   = 8'hF2;
  localparam logic [3:0] TRIO_NIB   = 4'hF;
  localparam logic [1:0] TRIO_MAX   = 2'd3;
  localparam logic [WCNT_W-1:0] TRIO_PITCH = WCNT_W'(3);
  localparam logic [1:0] PICK_NONE  = 2'd3;

  typedef enum logic [3:0] {
    PH_SEEK   = 4'b0001,
    PH_WINDOW = 4'b0010,
    PH_CHECK  = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_LIVE = 2'd0,
    KIND_REC  = 2'd1,
    KIND_HDR  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] pulse_rate;
    logic [7:0] oxygen_sat;
    logic [7:0] pleth_wave;
    logic [6:0] start_hour;
    logic [6:0] start_minute;
    logic       no_clock;
  } osd_result_t;

  typedef logic [2:0][WCNT_W-1:0] off_arr_t;
  typedef logic [2:0][6:0]        time_arr_t;

  // Best trio: 0 or 1 when the next trio sits exactly one trio later, else PICK_NONE.
  function automatic logic [1:0] pick_trio(input logic [1:0] tcnt, input off_arr_t toff);
    logic [1:0] best;
    best = PICK_NONE;
    if (tcnt >= 2'd2 && (toff[1] - toff[0]) == TRIO_PITCH) begin
      best = 2'd0;
    end else if (tcnt == TRIO_MAX && (toff[2] - toff[1]) == TRIO_PITCH) begin
      best = 2'd1;
    end
    return best;
  endfunction

  function automatic osd_result_t header_result(input logic [1:0] tcnt, input off_arr_t toff,
                                                input time_arr_t thour, input time_arr_t tmin,
                                                input logic [7:0] check_byte);
    logic [1:0]  best;
    logic [1:0]  last;
    logic [6:0]  h;
    logic [6:0]  m;
    osd_result_t r;
    best = pick_trio(tcnt, toff);
    last = tcnt - 2'd1;
    h = '0;
    m = '0;
    if (best != PICK_NONE) begin
      h = thour[best];
      m = tmin[best];
    end else if (tcnt != 2'd0 && check_byte[7:4] == TRIO_NIB) begin
      h = thour[last];
      m = tmin[last];
    end
    r = '0;
    r.kind = KIND_HDR;
    r.start_hour = h;
    r.start_minute = m;
    r.no_clock = (h == '0) && (m == '0);
    return r;
  endfunction

endpackage

// ----- rtl/osd_in_stage.sv -----
// Input register stage: holds one received byte until the deframer takes it.
module osd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= byte_in_i;
    end
  end

endmodule

// ----- rtl/osd_deframer.sv -----
// Deframer state and the per-byte next-state and result logic.
module osd_deframer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output logic                 res_valid_o,
  output osd_pkg::osd_result_t res_o
);

  logic                        mode_q;
  osd_pkg::phase_e             phase_q, phase_d;
  logic [2:0]                  fpos_q, fpos_d;
  logic [2:0][7:0]             held_q, held_d;
  logic [osd_pkg::WCNT_W-1:0]  wcnt_q, wcnt_d;
  logic [1:0]                  tcnt_q, tcnt_d;
  osd_pkg::off_arr_t           toff_q, toff_d;
  osd_pkg::time_arr_t          thour_q, thour_d;
  osd_pkg::time_arr_t          tmin_q, tmin_d;
  logic                        chk_q, chk_d;

  logic [2:0] fpos_m1;
  logic [1:0] tlast;

  assign fpos_m1 = fpos_q - 3'd1;
  assign tlast   = tcnt_q - 2'd1;

  always_comb begin
    phase_d = phase_q;
    fpos_d  = fpos_q;
    held_d  = held_q;
    wcnt_d  = wcnt_q;
    tcnt_d  = tcnt_q;
    toff_d  = toff_q;
    thour_d = thour_q;
    tmin_d  = tmin_q;
    chk_d   = chk_q;
    res_valid_o = 1'b0;
    res_o = '0;

    if (step_i) begin
      if (!mode_q) begin
        // live frames: sync byte, then four more bytes
        if (phase_q != osd_pkg::PH_DATA) begin
          if ((byte_i & osd_pkg::SYNC_BIT) != 8'h00) begin
            phase_d = osd_pkg::PH_DATA;
            fpos_d  = 3'd1;
          end else begin
            phase_d = osd_pkg::PH_SEEK;
          end
        end else if (fpos_q >= 3'd1 && fpos_q <= 3'd3) begin
          held_d[fpos_m1[1:0]] = byte_i;
          fpos_d = fpos_q + 3'd1;
        end else begin
          phase_d = osd_pkg::PH_SEEK;
          fpos_d  = 3'd0;
          res_valid_o = 1'b1;
          res_o.kind = osd_pkg::KIND_LIVE;
          res_o.pulse_rate = {held_q[1][6], held_q[2][6:0]};
          res_o.oxygen_sat = {1'b0, byte_i[6:0]};
          res_o.pleth_wave = held_q[0];
        end
      end else begin
        unique case (phase_q)
          osd_pkg::PH_SEEK: begin
            if (byte_i == osd_pkg::HDR_MARK) begin
              phase_d   = osd_pkg::PH_WINDOW;
              tcnt_d    = 2'd1;
              toff_d[0] = '0;
              wcnt_d    = osd_pkg::WCNT_W'(1);
              fpos_d    = 3'd1;
              chk_d     = 1'b0;
            end
          end
          osd_pkg::PH_WINDOW: begin
            if (fpos_q == 3'd1) begin
              if (tcnt_q != 2'd0) thour_d[tlast] = byte_i[6:0];
              fpos_d = 3'd2;
            end else if (fpos_q == 3'd2) begin
              if (tcnt_q != 2'd0) tmin_d[tlast] = byte_i[6:0];
              fpos_d = 3'd0;
              chk_d  = 1'b1;
            end else begin
              if (chk_q) begin
                held_d[0] = byte_i;
                chk_d = 1'b0;
              end
              if (byte_i == osd_pkg::HDR_MARK && tcnt_q != osd_pkg::TRIO_MAX &&
                  wcnt_q < osd_pkg::HDR_WIN) begin
                toff_d[tcnt_q] = wcnt_q;
                tcnt_d = tcnt_q + 2'd1;
                fpos_d = 3'd1;
              end
            end
            if (wcnt_q < osd_pkg::HDR_WIN) wcnt_d = wcnt_q + osd_pkg::WCNT_W'(1);
            // window closes: emit now, or wait one byte for the check byte
            if (fpos_d == 3'd0 && (tcnt_d == osd_pkg::TRIO_MAX || wcnt_d >= osd_pkg::HDR_WIN)) begin
              if (osd_pkg::pick_trio(tcnt_d, toff_d) == osd_pkg::PICK_NONE && chk_d) begin
                phase_d = osd_pkg::PH_CHECK;
              end else begin
                res_valid_o = 1'b1;
                res_o = osd_pkg::header_result(tcnt_d, toff_d, thour_d, tmin_d, held_d[0]);
                phase_d = osd_pkg::PH_DATA;
                fpos_d  = 3'd0;
              end
            end
          end
          osd_pkg::PH_CHECK: begin
            held_d[0] = byte_i;
            chk_d = 1'b0;
            res_valid_o = 1'b1;
            res_o = osd_pkg::header_result(tcnt_q, toff_q, thour_q, tmin_q, byte_i);
            phase_d = osd_pkg::PH_DATA;
            fpos_d  = 3'd0;
            // same byte also opens the first data trio
            if (byte_i[7:4] == osd_pkg::TRIO_NIB) fpos_d = 3'd1;
          end
          osd_pkg::PH_DATA: begin
            if (fpos_q == 3'd0) begin
              if (byte_i[7:4] == osd_pkg::TRIO_NIB) begin
                held_d[0] = byte_i;
                fpos_d = 3'd1;
              end
            end else if (fpos_q == 3'd1) begin
              held_d[1] = byte_i;
              fpos_d = 3'd2;
            end else begin
              fpos_d = 3'd0;
              res_valid_o = 1'b1;
              res_o.kind = osd_pkg::KIND_REC;
              res_o.pulse_rate = {held_q[0][0], held_q[1][6:0]};
              res_o.oxygen_sat = byte_i;
            end
          end
          default: begin
            phase_d = osd_pkg::PH_SEEK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      phase_q <= osd_pkg::PH_SEEK;
      fpos_q  <= '0;
      held_q  <= '0;
      wcnt_q  <= '0;
      tcnt_q  <= '0;
      toff_q  <= '0;
      thour_q <= '0;
      tmin_q  <= '0;
      chk_q   <= 1'b0;
    end else if (cfg_we_i) begin
      // any mode write restarts the deframer
      mode_q  <= cfg_wdata_i;
      phase_q <= osd_pkg::PH_SEEK;
      fpos_q  <= '0;
      held_q  <= '0;
      wcnt_q  <= '0;
      tcnt_q  <= '0;
      toff_q  <= '0;
      thour_q <= '0;
      tmin_q  <= '0;
      chk_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      fpos_q  <= fpos_d;
      held_q  <= held_d;
      wcnt_q  <= wcnt_d;
      tcnt_q  <= tcnt_d;
      toff_q  <= toff_d;
      thour_q <= thour_d;
      tmin_q  <= tmin_d;
      chk_q   <= chk_d;
    end
  end

endmodule

// ----- rtl/osd_out_stage.sv -----
// Output register stage: holds one result until the sink takes it.
module osd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  osd_pkg::osd_result_t res_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output osd_pkg::osd_result_t res_o
);

  logic                 valid_q;
  osd_pkg::osd_result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- rtl/oximeter_serial_deframer_top.sv -----
// Top level of the oximeter serial deframer.
// Order: a byte accepted into the input register is decoded once the output register is free;
// its result, if any, is registered there and shows on the output port.
// Throughput: one byte per cycle, set by the single decode pass between the
// input register and the result register; a stalled output holds the input side.
// Reset: asynchronous, active low; live mode, seeking sync, no transaction pending.
module oximeter_serial_deframer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] pulse_rate_o,
  output logic [7:0] oxygen_sat_o,
  output logic [7:0] pleth_wave_o,
  output logic [6:0] start_hour_o,
  output logic [6:0] start_minute_o,
  output logic       no_clock_o
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 out_free;
  logic                 step;
  logic                 res_valid;
  osd_pkg::osd_result_t res;
  osd_pkg::osd_result_t res_out;

  assign step = s1_valid && out_free;

  osd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .byte_in_i  (byte_in_i),
    .take_i     (step),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  osd_deframer u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .byte_i      (s1_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  osd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign kind_o         = res_out.kind;
  assign pulse_rate_o   = res_out.pulse_rate;
  assign oxygen_sat_o   = res_out.oxygen_sat;
  assign pleth_wave_o   = res_out.pleth_wave;
  assign start_hour_o   = res_out.start_hour;
  assign start_minute_o = res_out.start_minute;
  assign no_clock_o     = res_out.no_clock;

endmodule

// ----- rtl/osd_checker.sv -----
// Port-level checks for the oximeter deframer, bound to the top level.
module osd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] pulse_rate_o,
  input logic [7:0] oxygen_sat_o,
  input logic [7:0] pleth_wave_o,
  input logic [6:0] start_hour_o,
  input logic [6:0] start_minute_o,
  input logic       no_clock_o
);

  // stalled result transaction holds its kind, pulse rate, SpO2 and start hour
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(pulse_rate_o) && $stable(oxygen_sat_o) && $stable(start_hour_o))
    else $error("result changed while stalled");

  a_hdr_noclk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == osd_pkg::KIND_HDR |->
    no_clock_o == (start_hour_o == 7'd0 && start_minute_o == 7'd0))
    else $error("no_clock flag disagrees with header time");

  a_sample_no_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != osd_pkg::KIND_HDR |->
    start_hour_o == 7'd0 && start_minute_o == 7'd0 && !no_clock_o)
    else $error("sample carries header fields");

  a_live_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == osd_pkg::KIND_LIVE |-> !oxygen_sat_o[7])
    else $error("live SpO2 not masked");

  a_nonlive_pleth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != osd_pkg::KIND_LIVE |-> pleth_wave_o == 8'd0)
    else $error("pleth byte on non-live result");

endmodule

bind oximeter_serial_deframer_top osd_checker u_osd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .pulse_rate_o   (pulse_rate_o),
  .oxygen_sat_o   (oxygen_sat_o),
  .pleth_wave_o   (pleth_wave_o),
  .start_hour_o   (start_hour_o),
  .start_minute_o (start_minute_o),
  .no_clock_o     (no_clock_o)
);

// ----- bench/oximeter_serial_deframer_top_tb.sv -----
// Self-checking testbench for the oximeter serial deframer: live frames, header pick, data trios.
module oximeter_serial_deframer_top_tb;
  import osd_pkg::*;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] byte_in_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] pulse_rate_o;
  logic [7:0] oxygen_sat_o;
  logic [7:0] pleth_wave_o;
  logic [6:0] start_hour_o;
  logic [6:0] start_minute_o;
  logic       no_clock_o;

  oximeter_serial_deframer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_in_i     (byte_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .pulse_rate_o  (pulse_rate_o),
    .oxygen_sat_o  (oxygen_sat_o),
    .pleth_wave_o  (pleth_wave_o),
    .start_hour_o  (start_hour_o),
    .start_minute_o(start_minute_o),
    .no_clock_o    (no_clock_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Deframer state as predicted by the bench
  logic              mode_q;
  phase_e            ph_q;
  logic [2:0]        pos_q;
  logic [7:0]        held_q [3];
  logic [WCNT_W-1:0] win_q;
  logic [1:0]        ntrio_q;
  logic [WCNT_W-1:0] toff_q [3];
  logic [6:0]        thr_q [3];
  logic [6:0]        tmn_q [3];
  logic              chk_q;

  osd_result_t due_samples [$];
  logic [7:0]  tx_bytes [$];
  int          sent_bytes    = 0;
  int          errors        = 0;
  int          in_gap        = 0;
  int          out_stall     = 0;
  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;

  task automatic clear_deframer();
    ph_q    = PH_SEEK;
    pos_q   = '0;
    win_q   = '0;
    ntrio_q = '0;
    chk_q   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      held_q[i] = '0;
      toff_q[i] = '0;
      thr_q[i]  = '0;
      tmn_q[i]  = '0;
    end
  endtask

  initial begin
    mode_q = 1'b0;
    clear_deframer();
  end

  function automatic logic [1:0] best_trio();
    logic [1:0] pick;
    pick = PICK_NONE;
    if (ntrio_q >= 2'd2 && toff_q[1] - toff_q[0] == TRIO_PITCH) begin
      pick = 2'd0;
    end else if (ntrio_q == TRIO_MAX && toff_q[2] - toff_q[1] == TRIO_PITCH) begin
      pick = 2'd1;
    end
    return pick;
  endfunction

  task automatic push_header_time();
    logic [1:0]  pick;
    logic [6:0]  h;
    logic [6:0]  m;
    osd_result_t r;
    pick = best_trio();
    h = '0;
    m = '0;
    if (pick != PICK_NONE) begin
      h = thr_q[pick];
      m = tmn_q[pick];
    end else if (ntrio_q != 2'd0 && held_q[0][7:4] == TRIO_NIB) begin
      // no evenly spaced pair: last trio is trusted only if the next byte looks like data
      h = thr_q[ntrio_q - 2'd1];
      m = tmn_q[ntrio_q - 2'd1];
    end
    r = '0;
    r.kind = KIND_HDR;
    r.start_hour = h;
    r.start_minute = m;
    r.no_clock = (h == '0) && (m == '0);
    due_samples = {due_samples, r};
    ph_q  = PH_DATA;
    pos_q = '0;
  endtask

  task automatic data_trio_byte(input logic [7:0] b);
    osd_result_t r;
    if (pos_q == 3'd0) begin
      if (b[7:4] == TRIO_NIB) begin
        held_q[0] = b;
        pos_q = 3'd1;
      end
    end else if (pos_q == 3'd1) begin
      held_q[1] = b;
      pos_q = 3'd2;
    end else begin
      pos_q = 3'd0;
      r = '0;
      r.kind = KIND_REC;
      r.pulse_rate = {held_q[0][0], held_q[1][6:0]};
      r.oxygen_sat = b;
      due_samples = {due_samples, r};
    end
  endtask

  task automatic header_window_byte(input logic [7:0] b);
    if (pos_q == 3'd1) begin
      if (ntrio_q != 2'd0) thr_q[ntrio_q - 2'd1] = b[6:0];
      pos_q = 3'd2;
    end else if (pos_q == 3'd2) begin
      if (ntrio_q != 2'd0) tmn_q[ntrio_q - 2'd1] = b[6:0];
      pos_q = 3'd0;
      chk_q = 1'b1;
    end else begin
      if (chk_q) begin
        held_q[0] = b;
        chk_q = 1'b0;
      end
      if (b == HDR_MARK && ntrio_q < TRIO_MAX && win_q < HDR_WIN) begin
        toff_q[ntrio_q] = win_q;
        ntrio_q = ntrio_q + 2'd1;
        pos_q = 3'd1;
      end
    end
    if (win_q < HDR_WIN) win_q = win_q + WCNT_W'(1);
    if (pos_q == 3'd0 && (ntrio_q == TRIO_MAX || win_q >= HDR_WIN)) begin
      if (best_trio() == PICK_NONE && chk_q) ph_q = PH_CHECK;
      else push_header_time();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    osd_result_t r;
    if (!mode_q) begin
      if (ph_q != PH_DATA) begin
        if ((b & SYNC_BIT) != 8'h00) begin
          ph_q  = PH_DATA;
          pos_q = 3'd1;
        end else begin
          ph_q = PH_SEEK;
        end
      end else if (pos_q >= 3'd1 && pos_q <= 3'd3) begin
        held_q[2'(pos_q - 3'd1)] = b;
        pos_q = pos_q + 3'd1;
      end else begin
        ph_q  = PH_SEEK;
        pos_q = 3'd0;
        r = '0;
        r.kind = KIND_LIVE;
        r.pulse_rate = {held_q[1][6], held_q[2][6:0]};
        r.oxygen_sat = {1'b0, b[6:0]};
        r.pleth_wave = held_q[0];
        due_samples = {due_samples, r};
      end
    end else begin
      case (ph_q)
        PH_SEEK: begin
          if (b == HDR_MARK) begin
            ph_q      = PH_WINDOW;
            ntrio_q   = 2'd1;
            toff_q[0] = '0;
            win_q     = WCNT_W'(1);
            pos_q     = 3'd1;
            chk_q     = 1'b0;
          end
        end
        PH_WINDOW: header_window_byte(b);
        PH_CHECK: begin
          // late check byte: header goes out first, then the byte counts as data
          held_q[0] = b;
          chk_q = 1'b0;
          push_header_time();
          data_trio_byte(b);
        end
        default: data_trio_byte(b);
      endcase
    end
  endtask

  function automatic int idle_len(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Byte driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) deframe_byte(byte_in_i);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          byte_in_i  <= tx_bytes.pop_front();
          in_valid_i <= 1'b1;
          in_gap = idle_len(in_idle_pct);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result monitor and output backpressure
  always @(posedge clk_i) begin
    osd_result_t r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_samples.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual kind %0d",
                   $time, kind_o);
          errors++;
        end else begin
          r = due_samples.pop_front();
          check_field("kind", 8'(r.kind), 8'(kind_o));
          check_field("pulse_rate", r.pulse_rate, pulse_rate_o);
          check_field("oxygen_sat", r.oxygen_sat, oxygen_sat_o);
          check_field("pleth_wave", r.pleth_wave, pleth_wave_o);
          check_field("start_hour", 8'(r.start_hour), 8'(start_hour_o));
          check_field("start_minute", 8'(r.start_minute), 8'(start_minute_o));
          check_field("no_clock", 8'(r.no_clock), 8'(no_clock_o));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_stall = idle_len(out_stall_pct);
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    tx_bytes = {tx_bytes, b};
    sent_bytes++;
  endtask

  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == HDR_MARK) b = 8'h00;
    if ($urandom_range(0, 39) == 0) b = HDR_MARK;
    return b;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 40;
    endcase
  endfunction

  task automatic settle();
    while (tx_bytes.size() != 0 || in_valid_i || due_samples.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
    clear_deframer();
  endtask

  task automatic build_live();
    repeat ($urandom_range(8, 30)) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
      end
      queue_byte(SYNC_BIT | 8'($urandom_range(0, 127)));
      repeat (4) queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_import();
    int  ntrio;
    int  gap;
    int  off;
    bit  zero;
    ntrio = $urandom_range(1, 3);
    repeat ($urandom_range(0, 3)) queue_byte(filler_byte());
    off = 0;
    for (int t = 0; t < ntrio; t++) begin
      if (t > 0) begin
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
        if ($urandom_range(0, 9) == 0) gap = $urandom_range(18, 26);
        if (off + gap > 29) gap = 29 - off;
        repeat (gap) queue_byte(filler_byte());
        off += gap;
      end
      zero = ($urandom_range(0, 5) == 0);
      queue_byte(HDR_MARK);
      queue_byte(zero ? 8'h00 : 8'($urandom_range(0, 255)));
      queue_byte(zero ? 8'h00 : 8'($urandom_range(0, 255)));
      off += 3;
    end
    // byte after the last trio decides the fallback
    if ($urandom_range(0, 1) == 0) queue_byte({TRIO_NIB, 4'($urandom_range(0, 15))});
    else queue_byte(8'($urandom_range(0, 255)));
    off++;
    if (ntrio < 3) begin
      while (off < 30) begin
        queue_byte(filler_byte());
        off++;
      end
    end
    repeat ($urandom_range(8, 30)) begin
      if ($urandom_range(0, 4) == 0) queue_byte(8'($urandom_range(0, 8'hEF)));
      queue_byte({TRIO_NIB, 4'($urandom_range(0, 15))});
      queue_byte(8'($urandom_range(0, 255)));
      queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // live frames: extremes, inner bytes with bit 7 set, pulse bit 7 from byte two
    set_mode(1'b0);
    queue_byte(8'h00);
    queue_byte(8'h80); repeat (4) queue_byte(8'h00);
    queue_byte(8'hFF); repeat (4) queue_byte(8'hFF);
    queue_byte(8'hC5); queue_byte(8'h80); queue_byte(8'h40);
    queue_byte(8'h7F); queue_byte(8'hFF);
    settle();

    // import: skipped lead byte, evenly spaced trios, a first header with no clock
    set_mode(1'b1);
    queue_byte(8'h11);
    queue_byte(HDR_MARK); queue_byte(8'h00); queue_byte(8'h00);
    queue_byte(HDR_MARK); queue_byte(8'h85); queue_byte(8'h3B);
    queue_byte(HDR_MARK); queue_byte(8'h17); queue_byte(8'h2D);
    queue_byte(8'hF1); queue_byte(8'h80); queue_byte(8'h62);
    settle();

    while (sent_bytes < 1900) begin
      in_idle_pct   = pick_pct();
      out_stall_pct = pick_pct();
      if ($urandom_range(0, 4) < 2) begin
        set_mode(1'b0);
        build_live();
      end else begin
        set_mode(1'b1);
        build_import();
      end
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS oximeter_serial_deframer_top");
    end else begin
      $display("FAIL oximeter_serial_deframer_top");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL oximeter_serial_deframer_top");
    $finish;
  end

endmodule
